FILE: rtl/sprite_attribute_tile_expander_core_assert.svh
// ----------------------------------------------------------------------------
// sprite attribute tile expander assertion macros
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef SPRITE_ATTRIBUTE_TILE_EXPANDER_CORE_ASSERT_SVH
`define SPRITE_ATTRIBUTE_TILE_EXPANDER_CORE_ASSERT_SVH

// same-cycle implication or plain condition
`define SATE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition in one cycle implies a condition in the next
`define SATE_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);

`endif

FILE: rtl/sate_pkg.sv
// ----------------------------------------------------------------------------
// sate_pkg
// types, constants and lookup functions of the sprite tile expander
// ----------------------------------------------------------------------------
package sate_pkg;

    localparam logic MODE_16PX = 1'b0;
    localparam logic MODE_8PX  = 1'b1;

    localparam logic REG_LAYOUT_MODE    = 1'b0;
    localparam logic REG_SCREEN_FLIPPED = 1'b1;

    localparam logic [9:0] X_OFF_16PX = 10'd40;
    localparam logic [9:0] X_OFF_8PX  = 10'd69;
    localparam logic [9:0] Y_OFF      = 10'd32;
    localparam logic [7:0] Y_BIAS_16PX = 8'd1;
    localparam logic [7:0] Y_BIAS_8PX  = 8'd0;

    typedef struct packed {
        logic        mode;
        logic [10:0] code;
        logic [7:0]  colour;
        logic        flip_x;
        logic        flip_y;
        logic [9:0]  xbase;
        logic [9:0]  ybase;
        logic [1:0]  sxz;
        logic [1:0]  syz;
    } desc_t;

    // size code to tile count minus one
    function automatic logic [1:0] size_map(input logic [1:0] sz);
        logic [1:0] res;
        res = 2'd0;
        unique case (sz)
            2'd0: res = 2'd1;
            2'd1: res = 2'd0;
            2'd2: res = 2'd3;
            2'd3: res = 2'd0;
            default: res = 2'd0;
        endcase
        return res;
    endfunction

    // sub-tile code offset
    function automatic logic [3:0] tile_offset(input logic mode, input logic [1:0] tr,
                                               input logic [1:0] tc);
        logic [3:0] res;
        res = 4'd0;
        if (mode == MODE_16PX)
        begin
            res = {2'b00, tr[0], tc[0]};
        end
        else
        begin
            res = {tr[1], tc[1], tr[0], tc[0]};
        end
        return res;
    endfunction

endpackage

FILE: rtl/sprite_attribute_tile_expander_core.sv
// ----------------------------------------------------------------------------
// sprite_attribute_tile_expander_core
// expands sprite attributes into one draw item per sub-tile
//
// channel   | handshake                      | payload
// ----------+--------------------------------+------------------------------
// input     | push / full                    | six attribute bytes
// result    | empty / pop                    | tile_code .. last_tile
// config    | psel penable pwrite pready     | paddr pwdata prdata
//
// a sprite yields (x tiles) * (y tiles) draw items, 1 to 16; the sub-tile walk
// emits one item per cycle while the result stage is empty or being popped
// a disabled sprite is taken and yields no item
// the front takes sprites while the queue has room, also while results stall
// reset clears the queue, the walk counters, the output stage and both registers
// ----------------------------------------------------------------------------
module sprite_attribute_tile_expander_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        tile_byte,
    input  logic [7:0]        colour_byte,
    input  logic [7:0]        y_byte,
    input  logic [7:0]        x_byte,
    input  logic [7:0]        shape_byte,
    input  logic [7:0]        control_byte,
    output logic              empty,
    input  logic              pop,
    output logic [10:0]       tile_code,
    output logic [7:0]        colour,
    output logic              flip_x,
    output logic              flip_y,
    output logic signed [9:0] pos_x,
    output logic signed [9:0] pos_y,
    output logic              last_tile
);
    import sate_pkg::*;

    logic  layout_mode_reg;
    logic  layout_mode_next;
    logic  screen_flipped_reg;
    logic  screen_flipped_next;
    logic  cfg_wr;
    logic  q_push;
    logic  q_pop;
    logic  q_valid;
    desc_t front_desc;
    desc_t head_desc;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        layout_mode_next    = layout_mode_reg;
        screen_flipped_next = screen_flipped_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_LAYOUT_MODE:    layout_mode_next    = pwdata[0];
                REG_SCREEN_FLIPPED: screen_flipped_next = pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        unique case (paddr[2])
            REG_LAYOUT_MODE:    prdata = {31'd0, layout_mode_reg};
            REG_SCREEN_FLIPPED: prdata = {31'd0, screen_flipped_reg};
            default:            prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            layout_mode_reg    <= 1'b0;
            screen_flipped_reg <= 1'b0;
        end
        else
        begin
            layout_mode_reg    <= layout_mode_next;
            screen_flipped_reg <= screen_flipped_next;
        end
    end

    sate_front u_front (
        .push           (push),
        .q_full         (full),
        .layout_mode    (layout_mode_reg),
        .screen_flipped (screen_flipped_reg),
        .tile_byte      (tile_byte),
        .colour_byte    (colour_byte),
        .y_byte         (y_byte),
        .x_byte         (x_byte),
        .shape_byte     (shape_byte),
        .control_byte   (control_byte),
        .q_push         (q_push),
        .q_desc         (front_desc)
    );

    sate_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (q_push),
        .wr_desc  (front_desc),
        .full     (full),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_desc  (head_desc)
    );

    sate_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_desc    (head_desc),
        .q_pop     (q_pop),
        .pop       (pop),
        .empty     (empty),
        .tile_code (tile_code),
        .colour    (colour),
        .flip_x    (flip_x),
        .flip_y    (flip_y),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .last_tile (last_tile)
    );

endmodule

FILE: rtl/sate_front.sv
// ----------------------------------------------------------------------------
// sate_front
// accepts sprite attributes, drops disabled sprites, decodes the rest
// ----------------------------------------------------------------------------
module sate_front (
    input  logic           push,
    input  logic           q_full,
    input  logic           layout_mode,
    input  logic           screen_flipped,
    input  logic [7:0]     tile_byte,
    input  logic [7:0]     colour_byte,
    input  logic [7:0]     y_byte,
    input  logic [7:0]     x_byte,
    input  logic [7:0]     shape_byte,
    input  logic [7:0]     control_byte,
    output logic           q_push,
    output sate_pkg::desc_t q_desc
);
    import sate_pkg::*;

    logic [1:0] sxz;
    logic [1:0] syz;
    logic [7:0] ybase8;
    logic [9:0] xraw;

    assign xraw   = {1'b0, control_byte[0], x_byte};
    assign q_push = push && !q_full && !control_byte[1];

    always_comb
    begin
        q_desc        = '0;
        q_desc.mode   = layout_mode;
        q_desc.flip_x = shape_byte[0] ^ screen_flipped;
        q_desc.flip_y = shape_byte[1] ^ screen_flipped;
        if (layout_mode == MODE_16PX)
        begin
            sxz           = {1'b0, shape_byte[2]};
            syz           = {1'b0, shape_byte[3]};
            q_desc.code   = {3'b000, tile_byte & ~{6'b0, shape_byte[3], shape_byte[2]}};
            q_desc.colour = colour_byte;
            q_desc.xbase  = xraw - X_OFF_16PX;
            ybase8        = Y_BIAS_16PX - y_byte - {3'b000, shape_byte[3], 4'b0000};
        end
        else
        begin
            sxz           = size_map(shape_byte[3:2]);
            syz           = size_map(shape_byte[5:4]);
            q_desc.code   = {1'b0, tile_byte, shape_byte[7:6]};
            q_desc.colour = {2'b00, colour_byte[5:0]};
            q_desc.xbase  = xraw - X_OFF_8PX;
            ybase8        = Y_BIAS_8PX - y_byte - {3'b000, syz, 3'b000};
        end
        q_desc.sxz   = sxz;
        q_desc.syz   = syz;
        q_desc.ybase = {2'b00, ybase8} - Y_OFF;
    end

endmodule

FILE: rtl/sate_queue.sv
// ----------------------------------------------------------------------------
// sate_queue
// short queue of decoded sprites between front and back
// ----------------------------------------------------------------------------
module sate_queue #(
    parameter int DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_en,
    input  sate_pkg::desc_t wr_desc,
    output logic            full,
    input  logic            rd_en,
    output logic            rd_valid,
    output sate_pkg::desc_t rd_desc
);
    import sate_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    desc_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign full     = (cnt_reg == CNT_FULL);
    assign rd_valid = (cnt_reg != '0);
    assign rd_desc  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_desc;
        end
    end

endmodule

FILE: rtl/sate_back.sv
// ----------------------------------------------------------------------------
// sate_back
// walks the sub-tiles of the head sprite, one item per cycle unless pop stalls
// ----------------------------------------------------------------------------
`include "sprite_attribute_tile_expander_core_assert.svh"

module sate_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  sate_pkg::desc_t    q_desc,
    output logic               q_pop,
    input  logic               pop,
    output logic               empty,
    output logic [10:0]        tile_code,
    output logic [7:0]         colour,
    output logic               flip_x,
    output logic               flip_y,
    output logic signed [9:0]  pos_x,
    output logic signed [9:0]  pos_y,
    output logic               last_tile
);
    import sate_pkg::*;

    logic [1:0]  row_reg;
    logic [1:0]  row_next;
    logic [1:0]  col_reg;
    logic [1:0]  col_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic [10:0] code_reg;
    logic [7:0]  colour_reg;
    logic        fx_reg;
    logic        fy_reg;
    logic [9:0]  px_reg;
    logic [9:0]  py_reg;
    logic        last_reg;

    logic        advance;
    logic        is_last;
    logic [1:0]  tr;
    logic [1:0]  tc;
    logic [3:0]  off;
    logic [9:0]  dx;
    logic [9:0]  dy;

    assign advance = q_valid && (!out_valid_reg || pop);
    assign is_last = (row_reg == q_desc.syz) && (col_reg == q_desc.sxz);
    assign q_pop   = advance && is_last;

    assign tr  = row_reg ^ (q_desc.flip_y ? q_desc.syz : 2'd0);
    assign tc  = col_reg ^ (q_desc.flip_x ? q_desc.sxz : 2'd0);
    assign off = tile_offset(q_desc.mode, tr, tc);
    assign dx  = (q_desc.mode == MODE_16PX) ? {4'b0, col_reg, 4'b0} : {5'b0, col_reg, 3'b0};
    assign dy  = (q_desc.mode == MODE_16PX) ? {4'b0, row_reg, 4'b0} : {5'b0, row_reg, 3'b0};

    always_comb
    begin
        row_next       = row_reg;
        col_next       = col_reg;
        out_valid_next = out_valid_reg;
        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
        if (advance)
        begin
            out_valid_next = 1'b1;
            if (is_last)
            begin
                row_next = 2'd0;
                col_next = 2'd0;
            end
            else if (col_reg == q_desc.sxz)
            begin
                row_next = row_reg + 2'd1;
                col_next = 2'd0;
            end
            else
            begin
                col_next = col_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= 2'd0;
            col_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg       <= row_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            code_reg   <= q_desc.code + {7'b0, off};
            colour_reg <= q_desc.colour;
            fx_reg     <= q_desc.flip_x;
            fy_reg     <= q_desc.flip_y;
            px_reg     <= q_desc.xbase + dx;
            py_reg     <= q_desc.ybase + dy;
            last_reg   <= is_last;
        end
    end

    assign empty     = !out_valid_reg;
    assign tile_code = code_reg;
    assign colour    = colour_reg;
    assign flip_x    = fx_reg;
    assign flip_y    = fy_reg;
    assign pos_x     = px_reg;
    assign pos_y     = py_reg;
    assign last_tile = last_reg;

    `SATE_ASSERT(a_col_in_range, q_valid |-> (col_reg <= q_desc.sxz), "column beyond size")
    `SATE_ASSERT(a_row_in_range, q_valid |-> (row_reg <= q_desc.syz), "row beyond size")
    `SATE_ASSERT_NEXT(a_restart, advance && is_last, (row_reg == 2'd0) && (col_reg == 2'd0), "walk not restarted")
    `SATE_ASSERT_NEXT(a_step, advance && !is_last, (row_reg != $past(row_reg)) || (col_reg != $past(col_reg)), "walk stalled")

endmodule

FILE: verif/sprite_attribute_tile_expander_core_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sprite_attribute_tile_expander_core_checker
// follows register writes on the config port, expands every accepted sprite
// into its expected sub-tile draw items and compares each popped item field
// by field with the oldest expected one
// ----------------------------------------------------------------------------
module sprite_attribute_tile_expander_core_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic              pready,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    input  logic              push,
    input  logic              full,
    input  logic [7:0]        tile_byte,
    input  logic [7:0]        colour_byte,
    input  logic [7:0]        y_byte,
    input  logic [7:0]        x_byte,
    input  logic [7:0]        shape_byte,
    input  logic [7:0]        control_byte,
    input  logic              empty,
    input  logic              pop,
    input  logic [10:0]       tile_code,
    input  logic [7:0]        colour,
    input  logic              flip_x,
    input  logic              flip_y,
    input  logic signed [9:0] pos_x,
    input  logic signed [9:0] pos_y,
    input  logic              last_tile,
    output int                mismatches,
    output int                draws_checked,
    output int                draws_pending
);
    import sate_pkg::*;

    localparam int          REPORT_LIMIT = 10;
    localparam logic [9:0]  X_SHIFT_WIDE = 10'd40;
    localparam logic [9:0]  X_SHIFT_FINE = 10'd69;
    localparam logic [9:0]  Y_SHIFT      = 10'd32;

    // size code to tile count minus one in the 8-pixel layout
    localparam logic [1:0] SPAN_OF_CODE [4] = '{2'd1, 2'd0, 2'd3, 2'd0};
    // code offset of each sub-tile, the 16-pixel layout uses the top left 2x2
    localparam logic [3:0] SUBTILE_OFS [4][4] = '{
        '{4'd0,  4'd1,  4'd4,  4'd5},
        '{4'd2,  4'd3,  4'd6,  4'd7},
        '{4'd8,  4'd9,  4'd12, 4'd13},
        '{4'd10, 4'd11, 4'd14, 4'd15}
    };

    typedef struct packed {
        logic [10:0] code;
        logic [7:0]  colour;
        logic        flip_x;
        logic        flip_y;
        logic [9:0]  pos_x;
        logic [9:0]  pos_y;
        logic        last;
    } draw_cmd_t;

    draw_cmd_t expected_draws[$];
    draw_cmd_t got;
    draw_cmd_t want;
    logic      layout_sel;
    logic      flip_sel;
    int        fail_total;
    int        checked_total;

    initial
    begin
        layout_sel    = MODE_16PX;
        flip_sel      = 1'b0;
        fail_total    = 0;
        checked_total = 0;
    end

    function automatic void expand_sprite(input logic [7:0] tile, input logic [7:0] col,
                                          input logic [7:0] yb, input logic [7:0] xb,
                                          input logic [7:0] shape, input logic [7:0] ctrl);
        logic [1:0]  span_x;
        logic [1:0]  span_y;
        logic [1:0]  tr;
        logic [1:0]  tc;
        logic [10:0] base_code;
        logic [7:0]  bank;
        logic        fx;
        logic        fy;
        logic [9:0]  x0;
        logic [9:0]  y0;
        logic [9:0]  pitch;
        logic [7:0]  y_wrap;
        draw_cmd_t   cmd;
        if (ctrl[1])
            return;
        fx = shape[0] ^ flip_sel;
        fy = shape[1] ^ flip_sel;
        x0 = {1'b0, ctrl[0], xb};
        if (layout_sel == MODE_16PX)
        begin
            span_x    = {1'b0, shape[2]};
            span_y    = {1'b0, shape[3]};
            base_code = {3'b000, tile & ~{6'b000000, shape[3], shape[2]}};
            bank      = col;
            x0        = x0 - X_SHIFT_WIDE;
            y_wrap    = 8'd1 - yb - {3'b000, span_y[0], 4'b0000};
            pitch     = 10'd16;
        end
        else
        begin
            span_x    = SPAN_OF_CODE[shape[3:2]];
            span_y    = SPAN_OF_CODE[shape[5:4]];
            base_code = {1'b0, tile, shape[7:6]};
            bank      = {2'b00, col[5:0]};
            x0        = x0 - X_SHIFT_FINE;
            y_wrap    = 8'd0 - yb - {3'b000, span_y, 3'b000};
            pitch     = 10'd8;
        end
        y0 = {2'b00, y_wrap} - Y_SHIFT;
        for (int r = 0; r <= span_y; r++)
        begin
            for (int c = 0; c <= span_x; c++)
            begin
                tr         = 2'(r) ^ (fy ? span_y : 2'd0);
                tc         = 2'(c) ^ (fx ? span_x : 2'd0);
                cmd.code   = base_code + {7'd0, SUBTILE_OFS[tr][tc]};
                cmd.colour = bank;
                cmd.flip_x = fx;
                cmd.flip_y = fy;
                cmd.pos_x  = x0 + pitch * 10'(c);
                cmd.pos_y  = y0 + pitch * 10'(r);
                cmd.last   = (r == span_y) && (c == span_x);
                expected_draws.push_back(cmd);
            end
        end
    endfunction

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            layout_sel = MODE_16PX;
            flip_sel   = 1'b0;
            expected_draws.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == {REG_LAYOUT_MODE, 2'b00})
                    layout_sel = pwdata[0];
                else if (paddr == {REG_SCREEN_FLIPPED, 2'b00})
                    flip_sel = pwdata[0];
            end
            if (push && !full)
                expand_sprite(tile_byte, colour_byte, y_byte, x_byte, shape_byte, control_byte);
            if (pop && !empty)
            begin
                got = '{tile_code, colour, flip_x, flip_y, pos_x, pos_y, last_tile};
                checked_total++;
                if (expected_draws.size() == 0)
                begin
                    fail_total++;
                    if (fail_total <= REPORT_LIMIT)
                        $display("unexpected draw item: code %0d colour %0d x %0d y %0d",
                                 got.code, got.colour, $signed(got.pos_x), $signed(got.pos_y));
                end
                else
                begin
                    want = expected_draws.pop_front();
                    if (got !== want)
                    begin
                        fail_total++;
                        if (fail_total <= REPORT_LIMIT)
                            $display({"draw item %0d mismatch: expected code %0d colour %0d ",
                                      "fx %0d fy %0d x %0d y %0d last %0d, got code %0d ",
                                      "colour %0d fx %0d fy %0d x %0d y %0d last %0d"},
                                     checked_total, want.code, want.colour, want.flip_x,
                                     want.flip_y, $signed(want.pos_x), $signed(want.pos_y),
                                     want.last, got.code, got.colour, got.flip_x, got.flip_y,
                                     $signed(got.pos_x), $signed(got.pos_y), got.last);
                    end
                end
            end
        end
        mismatches    <= fail_total;
        draws_checked <= checked_total;
        draws_pending <= expected_draws.size();
    end

endmodule

FILE: verif/sprite_attribute_tile_expander_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sprite_attribute_tile_expander_core_tb
// drives sprites through the expander in both layouts with screen flip off
// and on: directed corner sprites first, then random ones, with random gaps
// on push and random stalls on pop; a checker beside the block predicts and
// compares every draw item
// ----------------------------------------------------------------------------
module sprite_attribute_tile_expander_core_tb;
    import sate_pkg::*;

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 24;
    localparam int RANDOM_ITEMS  = 34;
    localparam int CYCLE_LIMIT   = 200000;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [2:0]        paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    logic              push;
    logic              full;
    logic [7:0]        tile_byte;
    logic [7:0]        colour_byte;
    logic [7:0]        y_byte;
    logic [7:0]        x_byte;
    logic [7:0]        shape_byte;
    logic [7:0]        control_byte;
    logic              empty;
    logic              pop;
    logic [10:0]       tile_code;
    logic [7:0]        colour;
    logic              flip_x;
    logic              flip_y;
    logic signed [9:0] pos_x;
    logic signed [9:0] pos_y;
    logic              last_tile;

    int mismatches;
    int draws_checked;
    int draws_pending;
    int cycle_count = 0;
    int sprites_sent = 0;
    int sprites_disabled = 0;
    bit quiet_sender = 1'b0;

    always #CLK_HALF clk = ~clk;

    sprite_attribute_tile_expander_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .push         (push),
        .full         (full),
        .tile_byte    (tile_byte),
        .colour_byte  (colour_byte),
        .y_byte       (y_byte),
        .x_byte       (x_byte),
        .shape_byte   (shape_byte),
        .control_byte (control_byte),
        .empty        (empty),
        .pop          (pop),
        .tile_code    (tile_code),
        .colour       (colour),
        .flip_x       (flip_x),
        .flip_y       (flip_y),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .last_tile    (last_tile)
    );

    sprite_attribute_tile_expander_core_checker draw_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .push          (push),
        .full          (full),
        .tile_byte     (tile_byte),
        .colour_byte   (colour_byte),
        .y_byte        (y_byte),
        .x_byte        (x_byte),
        .shape_byte    (shape_byte),
        .control_byte  (control_byte),
        .empty         (empty),
        .pop           (pop),
        .tile_code     (tile_code),
        .colour        (colour),
        .flip_x        (flip_x),
        .flip_y        (flip_y),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .last_tile     (last_tile),
        .mismatches    (mismatches),
        .draws_checked (draws_checked),
        .draws_pending (draws_pending)
    );

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("sprite_attribute_tile_expander_core test failed");
            $finish;
        end
    end

    task automatic send_sprite(input logic [7:0] tile, input logic [7:0] col,
                               input logic [7:0] yb, input logic [7:0] xb,
                               input logic [7:0] shape, input logic [7:0] ctrl);
        int gap;
        gap = quiet_sender ? 0 : $urandom_range(0, 4);
        if (gap != 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push         <= 1'b1;
        tile_byte    <= tile;
        colour_byte  <= col;
        y_byte       <= yb;
        x_byte       <= xb;
        shape_byte   <= shape;
        control_byte <= ctrl;
        @(posedge clk);
        while (full) @(posedge clk);
        sprites_sent++;
        if (ctrl[1])
            sprites_disabled++;
    endtask

    task automatic send_random_sprite();
        logic [7:0] ctrl;
        ctrl = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 7) != 0)
            ctrl[1] = 1'b0;
        send_sprite(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), ctrl);
    endtask

    // stop pushing and wait until every expected draw item has been popped
    task automatic wait_drained();
        push <= 1'b0;
        @(posedge clk);
        while (draws_pending != 0) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic value);
        logic [31:0] word;
        word    = $urandom;
        word[0] = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // result side: random stalls, with runs of back-to-back pops
    initial
    begin
        int stall;
        int steady_left;
        steady_left = 0;
        pop <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (steady_left > 0)
                steady_left--;
            else if ($urandom_range(0, 5) == 0)
                steady_left = 20;
            stall = (steady_left > 0) ? 0 : $urandom_range(0, 4);
            if (stall != 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            @(posedge clk);
            while (empty) @(posedge clk);
        end
    end

    initial
    begin
        logic mode_sel;
        logic flip_sel;
        rst_n        <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        push         <= 1'b0;
        tile_byte    <= '0;
        colour_byte  <= '0;
        y_byte       <= '0;
        x_byte       <= '0;
        shape_byte   <= '0;
        control_byte <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // phases: 16px, 8px, 16px flipped, 8px flipped
        for (int phase = 0; phase < 4; phase++)
        begin
            mode_sel = (phase % 2 == 0) ? MODE_16PX : MODE_8PX;
            flip_sel = (phase >= 2);
            wait_drained();
            repeat (SETTLE_CYCLES) @(posedge clk);
            write_reg(REG_LAYOUT_MODE, mode_sel);
            write_reg(REG_SCREEN_FLIPPED, flip_sel);

            if (phase == 0)
            begin
                send_sprite(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
                send_sprite(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hfd);
                send_sprite(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff);
                send_sprite(8'h55, 8'haa, 8'h01, 8'h28, 8'h04, 8'h00);
                send_sprite(8'hab, 8'h3c, 8'hf0, 8'h80, 8'h0a, 8'h01);
                send_sprite(8'h13, 8'h81, 8'h10, 8'h00, 8'h0d, 8'h00);
            end
            else if (phase == 1)
            begin
                // every pair of size codes, the unused code included
                for (int sz = 0; sz < 16; sz++)
                    send_sprite(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                                {2'(sz), 4'(sz), 2'($urandom_range(0, 3))},
                                {6'($urandom_range(0, 63)), 1'b0, 1'($urandom_range(0, 1))});
                send_sprite(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'h01);
                send_sprite(8'h00, 8'h00, 8'h00, 8'h00, 8'h28, 8'hfe);
            end

            for (int n = 0; n < RANDOM_ITEMS; n++)
            begin
                quiet_sender = (n >= 25) && (n < 35);
                if (n == 20)
                    wait_drained();
                send_random_sprite();
            end
            quiet_sender = 1'b0;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("sent %0d sprites (%0d disabled), checked %0d draw items",
                 sprites_sent, sprites_disabled, draws_checked);
        $display("both layouts with screen flip off and on, all size codes and flips");
        if (mismatches == 0 && draws_pending == 0)
            $display("sprite_attribute_tile_expander_core test passed");
        else
            $display("sprite_attribute_tile_expander_core test failed");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl
rtl/sate_pkg.sv
rtl/sate_front.sv
rtl/sate_queue.sv
rtl/sate_back.sv
rtl/sprite_attribute_tile_expander_core.sv
verif/sprite_attribute_tile_expander_core_checker.sv
verif/sprite_attribute_tile_expander_core_tb.sv
